// ===== rtl/xtea_block_cipher_macros.svh =====
// ---------------------------------------------------------------------------
// XTEA block cipher assertion macros
// Shared concurrent assertion forms for the cipher RTL.
// ---------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_MACROS_SVH
`define XTEA_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, disabled while reset is applied
`define XTEA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied
`define XTEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/xtea_pkg.sv =====
// ---------------------------------------------------------------------------
// XTEA package
// Constants, types and the round mixing function shared by the cipher RTL.
// ---------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

	localparam logic [31:0] XTEA_DELTA = 32'h9E3779B9;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		REG_KEY_WORD_0 = 2'd0,
		REG_KEY_WORD_1 = 2'd1,
		REG_KEY_WORD_2 = 2'd2,
		REG_KEY_WORD_3 = 2'd3
	} reg_idx_t;

	typedef logic [3:0][31:0] key_t;

	// Word handed from one cell to the next
	typedef struct packed {
		logic        opcode;
		logic [31:0] left;
		logic [31:0] right;
		logic [31:0] sum;
	} stage_t;

	function automatic logic [31:0] xtea_mix(input logic [31:0] x, input logic [31:0] sum,
		input logic [31:0] kword);
		logic [31:0] t;
		t = ((x << 4) ^ (x >> 5)) + x;
		return t ^ (sum + kword);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/xtea_if.sv =====
// ---------------------------------------------------------------------------
// XTEA channel interfaces
// Valid/ready channels for input blocks, result blocks and key writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface xtea_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] data_left;
	logic [31:0] data_right;

	modport source (output valid, output opcode, output data_left, output data_right,
		input ready);
	modport sink (input valid, input opcode, input data_left, input data_right,
		output ready);
endinterface

interface xtea_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_left;
	logic [31:0] out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
endinterface

interface xtea_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/xtea_key_regs.sv =====
// ---------------------------------------------------------------------------
// XTEA key registers
// Holds the four 32-bit key words written through the configuration channel.
// ---------------------------------------------------------------------------
`default_nettype none

module xtea_key_regs
	import xtea_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	xtea_cfg_if.sink   cfg,
	output key_t       key
);

	key_t key_q;

	assign cfg.ready = 1'b1;
	assign key = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_KEY_WORD_0: key_q[0] <= cfg.data;
				REG_KEY_WORD_1: key_q[1] <= cfg.data;
				REG_KEY_WORD_2: key_q[2] <= cfg.data;
				REG_KEY_WORD_3: key_q[3] <= cfg.data;
				default: key_q <= key_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/xtea_cell.sv =====
// ---------------------------------------------------------------------------
// XTEA half-round cell
// One Feistel half-round with its own pipeline register and handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module xtea_cell
	import xtea_pkg::*;
#(
	parameter bit FIRST = 1'b1
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire key_t   key,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire stage_t in_data,
	output logic        out_valid,
	input  wire logic   out_ready,
	output stage_t      out_data
);

	logic        valid_s1;
	stage_t      data_s1;
	stage_t      next_data;
	logic        upd_y;
	logic [1:0]  ksel;
	logic [31:0] src;
	logic [31:0] tgt;
	logic [31:0] tgt_n;
	logic [31:0] mixed;

	// Left word always keys off sum[1:0], right word off sum[12:11]; the
	// direction swaps which half is updated first and whether mix and delta are added or subtracted.
	always_comb begin
		upd_y = ((in_data.opcode == OP_ENCRYPT) == FIRST);
		src   = upd_y ? in_data.right : in_data.left;
		tgt   = upd_y ? in_data.left : in_data.right;
		ksel  = upd_y ? in_data.sum[1:0] : in_data.sum[12:11];
		mixed = xtea_mix(src, in_data.sum, key[ksel]);
		tgt_n = (in_data.opcode == OP_ENCRYPT) ? tgt + mixed : tgt - mixed;

		next_data = in_data;
		if (upd_y) begin
			next_data.left = tgt_n;
		end else begin
			next_data.right = tgt_n;
		end
		if (FIRST) begin
			next_data.sum = (in_data.opcode == OP_ENCRYPT) ? in_data.sum + XTEA_DELTA
				: in_data.sum - XTEA_DELTA;
		end
	end

	// Advance when empty or when the neighbor takes the held word
	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= next_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/xtea_block_cipher.sv =====
// ---------------------------------------------------------------------------
// XTEA block cipher
// 64-bit block, 128-bit key, pipelined over a chain of half-round cells.
// ---------------------------------------------------------------------------
// A block enters on din with an opcode (encrypt or decrypt) and leaves on
// dout after passing the datapath, a chain of 2*ROUNDS half-round cells,
// one register each, so a new block is taken every cycle while din is
// ready, and up to 2*ROUNDS blocks are in flight. A stall on dout
// only closes bubbles in the chain; din stays ready until every cell holds a
// block. Key words are written on cfg at any time and take effect at once;
// change them only while no block is in flight.
`default_nettype none
`include "xtea_block_cipher_macros.svh"

module xtea_block_cipher
	import xtea_pkg::*;
#(
	parameter int ROUNDS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	xtea_in_if.sink     din,
	xtea_out_if.source  dout,
	xtea_cfg_if.sink    cfg
);

	localparam int          NUM_CELLS = 2 * ROUNDS;
	localparam int          CNT_W     = $clog2(NUM_CELLS + 1);
	localparam logic [63:0] DEC_PROD  = 64'(XTEA_DELTA) * 64'(ROUNDS);
	localparam logic [31:0] DEC_SUM   = DEC_PROD[31:0];

	key_t                 key;
	logic [NUM_CELLS:0]   cell_valid;
	logic [NUM_CELLS:0]   cell_ready;
	stage_t               cell_data [NUM_CELLS+1];
	logic [CNT_W-1:0]     count_q;

	xtea_key_regs u_key_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.key    (key)
	);

	assign cell_valid[0]       = din.valid;
	assign din.ready           = cell_ready[0];
	assign cell_data[0].opcode = din.opcode;
	assign cell_data[0].left   = din.data_left;
	assign cell_data[0].right  = din.data_right;
	assign cell_data[0].sum    = (din.opcode == OP_DECRYPT) ? DEC_SUM : '0;

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		xtea_cell #(
			.FIRST ((k % 2) == 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.key       (key),
			.in_valid  (cell_valid[k]),
			.in_ready  (cell_ready[k]),
			.in_data   (cell_data[k]),
			.out_valid (cell_valid[k+1]),
			.out_ready (cell_ready[k+1]),
			.out_data  (cell_data[k+1])
		);
	end

	assign dout.valid            = cell_valid[NUM_CELLS];
	assign cell_ready[NUM_CELLS] = dout.ready;
	assign dout.out_left         = cell_data[NUM_CELLS].left;
	assign dout.out_right        = cell_data[NUM_CELLS].right;

	// Blocks in flight: accepted on din and not yet taken from dout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + CNT_W'(din.valid && din.ready)
				- CNT_W'(dout.valid && dout.ready);
		end
	end

	`XTEA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(NUM_CELLS), "blocks in flight exceed cell count")
	`XTEA_ASSERT_IMP(a_count_cells, clk, arst_n, 1'b1, $countones(cell_valid[NUM_CELLS:1]) == int'(count_q), "cell valid bits disagree with blocks in flight")
	`XTEA_ASSERT_IMP(a_full_stall, clk, arst_n, !din.ready, count_q == CNT_W'(NUM_CELLS), "input stalled while a cell is empty")
	`XTEA_ASSERT_NEXT(a_drain, clk, arst_n, dout.valid && dout.ready && !din.valid, count_q == CNT_W'($past(count_q) - CNT_W'(1)), "delivered block not removed from chain")

endmodule

`default_nettype wire

// ===== tb/xtea_block_cipher_checker.sv =====
// ---------------------------------------------------------------------------
// XTEA block cipher checker
// Watches the key, input and result channels. Keeps its own copy of the key,
// computes the expected cipher block for every accepted input word and
// compares each accepted result word with the oldest expected block.
// ---------------------------------------------------------------------------
module xtea_block_cipher_checker
	import xtea_pkg::*;
#(
	parameter int ROUNDS = 32
) (
	input  logic clk,
	input  logic arst_n,
	xtea_in_if   din,
	xtea_out_if  dout,
	xtea_cfg_if  cfg,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic [31:0] left;
		logic [31:0] right;
	} block_t;

	key_t   key_shadow;
	block_t cipher_q[$];

	function automatic logic [31:0] feistel_f(input logic [31:0] x, input logic [31:0] s,
		input logic [31:0] k);
		return (((x << 4) ^ (x >> 5)) + x) ^ (s + k);
	endfunction

	function automatic block_t cipher_block(input logic op, input logic [31:0] l,
		input logic [31:0] r, input key_t key);
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] s;
		y = l;
		z = r;
		if (op == OP_ENCRYPT) begin
			s = '0;
			for (int i = 0; i < ROUNDS; i++) begin
				y = y + feistel_f(z, s, key[s[1:0]]);
				s = s + XTEA_DELTA;
				z = z + feistel_f(y, s, key[s[12:11]]);
			end
		end else begin
			s = XTEA_DELTA * ROUNDS;
			// walk the rounds backwards
			for (int i = 0; i < ROUNDS; i++) begin
				z = z - feistel_f(y, s, key[s[12:11]]);
				s = s - XTEA_DELTA;
				y = y - feistel_f(z, s, key[s[1:0]]);
			end
		end
		return '{left: y, right: z};
	endfunction

	assign pending = cipher_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_shadow <= '0;
			cipher_q.delete();
			errors <= 0;
		end else begin
			block_t want;
			int     bad;
			bad = 0;
			if (cfg.valid && cfg.ready)
				key_shadow[cfg.index] <= cfg.data;
			if (din.valid && din.ready)
				cipher_q.push_back(cipher_block(din.opcode, din.data_left, din.data_right,
					key_shadow));
			if (dout.valid && dout.ready) begin
				if (cipher_q.size() == 0) begin
					$display("%0t: unexpected result word, actual %h %h", $time,
						dout.out_left, dout.out_right);
					bad = bad + 1;
				end else begin
					want = cipher_q.pop_front();
					if (dout.out_left !== want.left) begin
						$display("%0t: out_left mismatch, expected %h actual %h", $time,
							want.left, dout.out_left);
						bad = bad + 1;
					end
					if (dout.out_right !== want.right) begin
						$display("%0t: out_right mismatch, expected %h actual %h", $time,
							want.right, dout.out_right);
						bad = bad + 1;
					end
				end
			end
			if (bad != 0)
				errors <= errors + bad;
		end
	end

endmodule

// ===== tb/xtea_block_cipher_tb.sv =====
// ---------------------------------------------------------------------------
// XTEA block cipher testbench
// Drives key writes and cipher blocks in both directions under several keys,
// with random gaps on the sender, random stalls on the receiver and one long
// receiver hold that backs the pipeline up; the checker scores the results.
// ---------------------------------------------------------------------------
module xtea_block_cipher_tb;
	import xtea_pkg::*;

	localparam int RANDOM_PER_KEY = 205;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic quiet;
	logic hold_req;
	int   chk_errors;
	int   chk_pending;

	xtea_in_if  din_if();
	xtea_out_if dout_if();
	xtea_cfg_if cfg_if();

	xtea_block_cipher #(.ROUNDS(32)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_if),
		.dout(dout_if),
		.cfg(cfg_if)
	);

	xtea_block_cipher_checker #(.ROUNDS(32)) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_if),
		.dout(dout_if),
		.cfg(cfg_if),
		.errors(chk_errors),
		.pending(chk_pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [31:0] pick_word();
		logic [31:0] bit_mask;
		bit_mask = 32'h1 << $urandom_range(0, 31);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return bit_mask;
			3: return ~bit_mask;
			default: return $urandom;
		endcase
	endfunction

	// Result side: stall per word, one long hold when asked
	initial begin
		int stall;
		dout_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 7);
			@(negedge clk);
			if (hold_req) begin
				dout_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall != 0) begin
				dout_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			dout_if.ready = 1'b1;
			do @(posedge clk); while (!dout_if.valid);
		end
	end

	task automatic send_block(input logic op, input logic [31:0] l, input logic [31:0] r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap != 0) begin
			din_if.valid = 1'b0;
			din_if.opcode = $urandom;
			din_if.data_left = $urandom;
			din_if.data_right = $urandom;
			repeat (gap) @(negedge clk);
		end
		din_if.valid = 1'b1;
		din_if.opcode = op;
		din_if.data_left = l;
		din_if.data_right = r;
		do @(posedge clk); while (!din_if.ready);
	endtask

	// Drop valid and let every block in flight come out
	task automatic drain();
		@(negedge clk);
		din_if.valid = 1'b0;
		while (chk_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_key(input key_t key);
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_if.valid = 1'b1;
			cfg_if.index = reg_idx_t'(i);
			cfg_if.data = key[i];
			do @(posedge clk); while (!cfg_if.ready);
		end
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic send_directed();
		logic [31:0] lefts[6];
		logic [31:0] rights[6];
		lefts = '{32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h01234567};
		rights = '{32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h00000001, 32'h89ABCDEF};
		for (int i = 0; i < 6; i++) begin
			send_block(OP_ENCRYPT, lefts[i], rights[i]);
			send_block(OP_DECRYPT, lefts[i], rights[i]);
		end
	endtask

	task automatic send_random(input bit with_hold);
		for (int i = 0; i < RANDOM_PER_KEY; i++) begin
			if (i % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			// sender keeps offering while the result side holds off
			if (with_hold && i == 10) begin
				quiet = 1'b1;
				hold_req = 1'b1;
			end
			send_block($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, pick_word(),
				pick_word());
		end
		quiet = 1'b0;
	endtask

	initial begin
		key_t key;
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		din_if.valid = 1'b0;
		din_if.opcode = OP_ENCRYPT;
		din_if.data_left = '0;
		din_if.data_right = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_KEY_WORD_0;
		cfg_if.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// key left at its reset value
		send_directed();
		send_random(1'b0);
		drain();

		key = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
		write_key(key);
		send_directed();
		send_random(1'b0);
		drain();

		key = '{32'h0C0D0E0F, 32'h08090A0B, 32'h04050607, 32'h00010203};
		write_key(key);
		send_random(1'b1);
		drain();

		for (int p = 0; p < 2; p++) begin
			for (int i = 0; i < 4; i++)
				key[i] = pick_word();
			write_key(key);
			send_random(1'b0);
			drain();
		end

		key = '0;
		write_key(key);
		send_random(1'b0);
		drain();
		repeat (80) @(posedge clk);

		if (chk_errors == 0 && chk_pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
